// ----- sv/gaussian_opacity_transfer_unit_macros.svh -----
// Assertion macros for the Gaussian opacity transfer unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef GAUSSIAN_OPACITY_TRANSFER_UNIT_MACROS_SVH
`define GAUSSIAN_OPACITY_TRANSFER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GOT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gaussian opacity transfer unit: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GOT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gaussian opacity transfer unit: next-cycle check failed");

`endif

// ----- sv/got_pkg.sv -----
// Shared types, constants and the Gaussian table of the opacity transfer unit.
// No dependencies; used by every other file of the block but the assertion macros.
package got_pkg;

    localparam int MAX_POINTS = 16;
    localparam int PT_IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PT_CNT_W = $clog2(MAX_POINTS + 1);

    localparam int GAUSS_ROM_ENTRIES = 256;
    localparam int ROM_IDX_W = $clog2(GAUSS_ROM_ENTRIES);
    localparam logic [63:0] GAUSS_N1 = 64'(GAUSS_ROM_ENTRIES - 1);
    localparam logic [63:0] GAUSS_DEN = GAUSS_N1 * GAUSS_N1;
    localparam logic [63:0] GAUSS_DEN_HALF = GAUSS_DEN / 2;

    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 18;
    localparam int DIV_Q_W = 31;
    localparam int DIV_CNT_W = 5;

    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 22;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd2;

    localparam logic OP_MAP = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATIO,
        S_LOAD,
        S_SETUP,
        S_XDIV,
        S_SQ,
        S_IDX,
        S_GAUSS,
        S_TERM1,
        S_TERM2,
        S_SUM,
        S_SCALE_LO,
        S_SCALE_HI,
        S_ROUND,
        S_NEXT,
        S_FINISH
    } got_state_t;

    typedef struct packed {
        logic [15:0] center;
        logic [14:0] peak;
        logic [14:0] half_width;
        logic [15:0] skew_x;
        logic [15:0] shape_y;
    } got_point_t;

    typedef logic [14:0] gauss_rom_t [GAUSS_ROM_ENTRIES];

    // Entry i holds exp(-4u^2), u = (2i-(N-1))/(N-1), built from a Taylor
    // series of exp(-t/256) that is squared eight times in Q.30.
    function automatic gauss_rom_t build_gauss_rom();
        gauss_rom_t rom;
        logic [63:0] half;
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] a3;
        logic [63:0] a4;
        logic [63:0] e;
        logic [63:0] ii;
        half = 64'd1 << 29;
        for (int i = 0; i < GAUSS_ROM_ENTRIES; i++) begin
            ii = 64'(i);
            m = (2 * ii >= GAUSS_N1) ? 2 * ii - GAUSS_N1 : GAUSS_N1 - 2 * ii;
            a = (((m * m) << 24) + GAUSS_DEN_HALF) / GAUSS_DEN;
            a2 = (a * a + half) >> 30;
            a3 = (a2 * a + half) >> 30;
            a4 = (a3 * a + half) >> 30;
            e = (64'd1 << 30) - a + a2 / 2 - a3 / 6 + a4 / 24;
            for (int k = 0; k < 8; k++) begin
                e = (e * e + half) >> 30;
            end
            rom[i] = 15'((e * 64'd16384 + half) >> 30);
        end
        return rom;
    endfunction

    localparam gauss_rom_t GAUSS_ROM = build_gauss_rom();

endpackage

// ----- sv/got_intf.sv -----
// Handshake channels of the opacity transfer unit: items, results, config.
// Depends on got_pkg for the configuration widths.
interface got_item_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] sample;
    logic [3:0]  point_index;
    logic [15:0] center;
    logic [14:0] peak;
    logic [14:0] half_width;
    logic [15:0] skew_x;
    logic [15:0] shape_y;

    modport source (output valid, operation, sample, point_index, center, peak,
                    half_width, skew_x, shape_y, input ready);
    modport sink (input valid, operation, sample, point_index, center, peak,
                  half_width, skew_x, shape_y, output ready);
endinterface

interface got_result_if;
    logic        valid;
    logic        ready;
    logic [14:0] opacity;

    modport source (output valid, opacity, input ready);
    modport sink (input valid, opacity, output ready);
endinterface

interface got_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [got_pkg::CFG_IDX_W-1:0]   index;
    logic [got_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/got_div.sv -----
// Shared signed divider, restoring, one quotient bit per cycle.
// Depends on got_pkg for operand widths.
module got_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [got_pkg::DIV_NUM_W-1:0] num,
    input  logic signed [got_pkg::DIV_DEN_W-1:0] den,
    output logic                                 done,
    output logic signed [got_pkg::DIV_NUM_W-1:0] quot
);

    logic                              busy_reg;
    logic                              done_reg;
    logic                              neg_reg;
    logic [got_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [got_pkg::DIV_DEN_W-2:0]     den_reg;
    logic [got_pkg::DIV_DEN_W-2:0]     rem_reg;
    logic [got_pkg::DIV_Q_W-1:0]       quo_reg;

    logic signed [got_pkg::DIV_NUM_W-1:0] num_abs;
    logic signed [got_pkg::DIV_DEN_W-1:0] den_abs;
    logic [got_pkg::DIV_DEN_W-1:0]        shifted;
    logic [got_pkg::DIV_DEN_W-1:0]        trial;
    logic                                 fits;

    assign num_abs = num[got_pkg::DIV_NUM_W-1] ? -num : num;
    assign den_abs = den[got_pkg::DIV_DEN_W-1] ? -den : den;
    assign shifted = {rem_reg, quo_reg[got_pkg::DIV_Q_W-1]};
    assign trial = shifted - {1'b0, den_reg};
    assign fits = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= got_pkg::DIV_CNT_W'(got_pkg::DIV_Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == got_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            neg_reg <= num[got_pkg::DIV_NUM_W-1] ^ den[got_pkg::DIV_DEN_W-1];
            quo_reg <= num_abs[got_pkg::DIV_Q_W-1:0];
            den_reg <= den_abs[got_pkg::DIV_DEN_W-2:0];
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[got_pkg::DIV_DEN_W-2:0]
                            : shifted[got_pkg::DIV_DEN_W-2:0];
            quo_reg <= {quo_reg[got_pkg::DIV_Q_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// ----- sv/got_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on got_pkg for operand widths.
module got_mul (
    input  logic                               clk,
    input  logic signed [got_pkg::MUL_A_W-1:0] a,
    input  logic signed [got_pkg::MUL_B_W-1:0] b,
    output logic signed [got_pkg::MUL_P_W-1:0] prod
);

    logic signed [got_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ----- sv/got_store.sv -----
// Control point memory: one write port, one registered read port.
// Depends on got_pkg for the point record and depth.
module got_store (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [got_pkg::PT_IDX_W-1:0]  wr_addr,
    input  got_pkg::got_point_t           wr_data,
    input  logic                          rd_en,
    input  logic [got_pkg::PT_IDX_W-1:0]  rd_addr,
    output got_pkg::got_point_t           rd_data
);

    got_pkg::got_point_t mem [got_pkg::MAX_POINTS];
    got_pkg::got_point_t rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/gaussian_opacity_transfer_unit.sv -----
// Gaussian opacity transfer unit: a control point write is stored from the idle state.
// A map beat runs the range division, then for each point a band check and,
// for a point inside its band, the offset division and curve steps, then it
// loads the result register; the shared 1-bit-per-cycle divider sets the pace.
// Reset clears control state and restores range 0..32767 and zero points;
// the point memory holds no reset value.
`include "gaussian_opacity_transfer_unit_macros.svh"

module gaussian_opacity_transfer_unit (
    input  logic         clk,
    input  logic         rst_n,
    got_cfg_if.sink      cfg,
    got_item_if.sink     items,
    got_result_if.source results
);

    got_pkg::got_state_t state_reg, state_next;

    logic [15:0] lo_reg, lo_next;
    logic [15:0] hi_reg, hi_next;
    logic [4:0]  pcount_reg, pcount_next;

    logic [got_pkg::PT_CNT_W-1:0] n_reg, n_next;
    logic [got_pkg::PT_CNT_W-1:0] p_reg, p_next;
    logic signed [31:0] ratio_reg, ratio_next;
    logic signed [17:0] d_reg, d_next;
    logic signed [17:0] w_reg, w_next;
    logic signed [21:0] x_reg, x_next;
    logic signed [27:0] par_reg, par_next;
    logic [14:0] gauss_reg, gauss_next;
    logic signed [43:0] s_reg, s_next;
    logic [36:0] acc_reg, acc_next;
    logic [14:0] best_reg, best_next;
    logic        res_valid_reg, res_valid_next;
    logic [14:0] res_reg, res_next;

    logic                                 div_start;
    logic signed [got_pkg::DIV_NUM_W-1:0] div_num;
    logic signed [got_pkg::DIV_DEN_W-1:0] div_den;
    logic                                 div_done;
    logic signed [got_pkg::DIV_NUM_W-1:0] div_quot;

    logic signed [got_pkg::MUL_A_W-1:0] mul_a;
    logic signed [got_pkg::MUL_B_W-1:0] mul_b;
    logic signed [got_pkg::MUL_P_W-1:0] mul_prod;

    logic                          st_wr_en;
    logic                          st_rd_en;
    logic [got_pkg::PT_IDX_W-1:0]  st_rd_addr;
    got_pkg::got_point_t           st_wr_data;
    got_pkg::got_point_t           pt;

    // Datapath helpers
    logic signed [16:0] samp_diff;
    logic signed [16:0] range_delta;
    logic signed [32:0] ratio33;
    logic signed [32:0] c33;
    logic signed [32:0] w33;
    logic               out_band;
    logic signed [17:0] k18;
    logic signed [17:0] d_minus_k;
    logic signed [17:0] k_minus_d;
    logic signed [17:0] w_minus_k;
    logic signed [17:0] w_plus_k;
    logic signed [21:0] x_clamped;
    logic [16:0]        xc_off;
    logic [28:0]        idx_sum;
    logic [13:0]        idx_full;
    logic [got_pkg::ROM_IDX_W-1:0] rom_idx;
    logic               y_low;
    logic signed [17:0] coef_a;
    logic signed [17:0] coef_b;
    logic [58:0]        round_sum;
    logic [30:0]        v_full;
    logic [14:0]        v_sat;
    logic               item_acc;
    logic               res_acc;

    got_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    got_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    got_store u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (got_pkg::PT_IDX_W'(items.point_index)),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (pt)
    );

    assign st_wr_data.center = items.center;
    assign st_wr_data.peak = items.peak;
    assign st_wr_data.half_width = items.half_width;
    assign st_wr_data.skew_x = items.skew_x;
    assign st_wr_data.shape_y = items.shape_y;

    assign items.ready = (state_reg == got_pkg::S_IDLE);
    assign cfg.ready = 1'b1;
    assign results.valid = res_valid_reg;
    assign results.opacity = res_reg;

    assign item_acc = items.valid && items.ready;
    assign res_acc = results.valid && results.ready;

    assign samp_diff = $signed({items.sample[15], items.sample})
                     - $signed({lo_reg[15], lo_reg});
    assign range_delta = $signed({hi_reg[15], hi_reg}) - $signed({lo_reg[15], lo_reg});

    assign ratio33 = {ratio_reg[31], ratio_reg};
    assign c33 = {{17{pt.center[15]}}, pt.center};
    assign w33 = $signed({18'd0, pt.half_width});
    assign out_band = (ratio33 > c33 + w33) || (ratio33 < c33 - w33);

    assign k18 = {{2{pt.skew_x[15]}}, pt.skew_x};
    assign d_minus_k = d_reg - k18;
    assign k_minus_d = k18 - d_reg;
    assign w_minus_k = w_reg - k18;
    assign w_plus_k = w_reg + k18;

    // Offset is clamped to plus or minus 64.0 before it is squared.
    assign x_clamped = (div_quot > 32'sd1048576) ? 22'sd1048576
                     : (div_quot < -32'sd1048576) ? -22'sd1048576
                     : div_quot[21:0];

    assign xc_off = (x_reg > 22'sd16384) ? 17'd32768
                  : (x_reg < -22'sd16384) ? 17'd0
                  : 17'(x_reg + 22'sd16384);

    assign idx_sum = mul_prod[28:0] + 29'd16384;
    assign idx_full = idx_sum[28:15];
    assign rom_idx = (32'(idx_full) > 32'(got_pkg::GAUSS_ROM_ENTRIES - 1))
                   ? got_pkg::ROM_IDX_W'(got_pkg::GAUSS_ROM_ENTRIES - 1)
                   : got_pkg::ROM_IDX_W'(idx_full);

    assign y_low = pt.shape_y < 16'd16384;
    assign coef_a = y_low ? $signed({2'b00, pt.shape_y})
                          : 18'sd32768 - $signed({2'b00, pt.shape_y});
    assign coef_b = y_low ? 18'sd16384 - $signed({2'b00, pt.shape_y})
                          : $signed({2'b00, pt.shape_y}) - 18'sd16384;

    assign round_sum = {1'b0, mul_prod[36:0], 21'd0} + 59'(acc_reg) + 59'd134217728;
    assign v_full = round_sum[58:28];
    assign v_sat = (v_full > 31'd32767) ? 15'd32767 : v_full[14:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= got_pkg::S_IDLE;
            lo_reg <= 16'd0;
            hi_reg <= 16'd32767;
            pcount_reg <= 5'd0;
            n_reg <= '0;
            p_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            pcount_reg <= pcount_next;
            n_reg <= n_next;
            p_reg <= p_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        ratio_reg <= ratio_next;
        d_reg <= d_next;
        w_reg <= w_next;
        x_reg <= x_next;
        par_reg <= par_next;
        gauss_reg <= gauss_next;
        s_reg <= s_next;
        acc_reg <= acc_next;
        best_reg <= best_next;
        res_reg <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        pcount_next = pcount_reg;
        n_next = n_reg;
        p_next = p_reg;
        ratio_next = ratio_reg;
        d_next = d_reg;
        w_next = w_reg;
        x_next = x_reg;
        par_next = par_reg;
        gauss_next = gauss_reg;
        s_next = s_reg;
        acc_next = acc_reg;
        best_next = best_reg;
        res_next = res_reg;
        res_valid_next = res_valid_reg && !res_acc;
        div_start = 1'b0;
        div_num = $signed(got_pkg::DIV_NUM_W'(samp_diff)) <<< 14;
        div_den = (range_delta == 17'sd0) ? 18'sd1 : 18'(range_delta);
        mul_a = '0;
        mul_b = '0;
        st_wr_en = 1'b0;
        st_rd_en = 1'b0;
        st_rd_addr = '0;

        if (cfg.valid && cfg.ready) begin
            unique case (cfg.index)
                got_pkg::CFG_RANGE_LOW:   lo_next = cfg.data;
                got_pkg::CFG_RANGE_HIGH:  hi_next = cfg.data;
                got_pkg::CFG_POINT_COUNT: pcount_next = cfg.data[4:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            got_pkg::S_IDLE: begin
                if (item_acc) begin
                    if (items.operation == got_pkg::OP_WRITE) begin
                        st_wr_en = 32'(items.point_index) < 32'(got_pkg::MAX_POINTS);
                    end else begin
                        div_start = 1'b1;
                        n_next = (32'(pcount_reg) > 32'(got_pkg::MAX_POINTS))
                               ? got_pkg::PT_CNT_W'(got_pkg::MAX_POINTS)
                               : got_pkg::PT_CNT_W'(pcount_reg);
                        p_next = '0;
                        best_next = '0;
                        state_next = got_pkg::S_RATIO;
                    end
                end
            end
            got_pkg::S_RATIO: begin
                if (div_done) begin
                    ratio_next = div_quot;
                    if (n_reg == '0) begin
                        state_next = got_pkg::S_FINISH;
                    end else begin
                        st_rd_en = 1'b1;
                        st_rd_addr = '0;
                        state_next = got_pkg::S_LOAD;
                    end
                end
            end
            got_pkg::S_LOAD: begin
                d_next = 18'(ratio33 - c33);
                w_next = (pt.half_width == 15'd0) ? 18'sd1 : $signed({3'b000, pt.half_width});
                state_next = out_band ? got_pkg::S_NEXT : got_pkg::S_SETUP;
            end
            got_pkg::S_SETUP: begin
                // Offset is rescaled on the side of the skew point it falls on.
                priority if (k18 == 18'sd0 || d_reg == k18) begin
                    div_num = $signed(got_pkg::DIV_NUM_W'(d_reg)) <<< 14;
                    div_den = w_reg;
                    div_start = 1'b1;
                    state_next = got_pkg::S_XDIV;
                end else if (d_reg > k18) begin
                    div_num = $signed(got_pkg::DIV_NUM_W'(d_minus_k)) <<< 14;
                    div_den = w_minus_k;
                    if (w_reg == k18) begin
                        x_next = '0;
                        state_next = got_pkg::S_SQ;
                    end else begin
                        div_start = 1'b1;
                        state_next = got_pkg::S_XDIV;
                    end
                end else begin
                    div_num = $signed(got_pkg::DIV_NUM_W'(k_minus_d)) <<< 14;
                    div_den = w_plus_k;
                    if (w_plus_k == 18'sd0) begin
                        x_next = '0;
                        state_next = got_pkg::S_SQ;
                    end else begin
                        div_start = 1'b1;
                        state_next = got_pkg::S_XDIV;
                    end
                end
            end
            got_pkg::S_XDIV: begin
                if (div_done) begin
                    x_next = x_clamped;
                    state_next = got_pkg::S_SQ;
                end
            end
            got_pkg::S_SQ: begin
                mul_a = got_pkg::MUL_A_W'(x_reg);
                mul_b = got_pkg::MUL_B_W'(x_reg);
                state_next = got_pkg::S_IDX;
            end
            got_pkg::S_IDX: begin
                par_next = 28'sd16384 - $signed({1'b0, mul_prod[40:14]});
                mul_a = $signed({11'd0, xc_off});
                mul_b = got_pkg::MUL_B_W'(got_pkg::GAUSS_ROM_ENTRIES - 1);
                state_next = got_pkg::S_GAUSS;
            end
            got_pkg::S_GAUSS: begin
                gauss_next = got_pkg::GAUSS_ROM[rom_idx];
                state_next = got_pkg::S_TERM1;
            end
            got_pkg::S_TERM1: begin
                mul_a = par_reg;
                mul_b = got_pkg::MUL_B_W'(coef_a);
                state_next = got_pkg::S_TERM2;
            end
            got_pkg::S_TERM2: begin
                s_next = 44'(mul_prod);
                mul_a = got_pkg::MUL_A_W'(coef_b);
                mul_b = y_low ? $signed({7'd0, gauss_reg}) : 22'sd16384;
                state_next = got_pkg::S_SUM;
            end
            got_pkg::S_SUM: begin
                s_next = s_reg + 44'(mul_prod);
                state_next = got_pkg::S_SCALE_LO;
            end
            got_pkg::S_SCALE_LO: begin
                // The product with the peak is formed in two halves.
                mul_a = $signed({7'd0, s_reg[20:0]});
                mul_b = $signed({7'd0, pt.peak});
                state_next = (s_reg <= 44'sd0) ? got_pkg::S_NEXT : got_pkg::S_SCALE_HI;
            end
            got_pkg::S_SCALE_HI: begin
                acc_next = mul_prod[36:0];
                mul_a = $signed({6'd0, s_reg[42:21]});
                mul_b = $signed({7'd0, pt.peak});
                state_next = got_pkg::S_ROUND;
            end
            got_pkg::S_ROUND: begin
                if (v_sat > best_reg) begin
                    best_next = v_sat;
                end
                state_next = got_pkg::S_NEXT;
            end
            got_pkg::S_NEXT: begin
                p_next = p_reg + 1'b1;
                if (p_next == n_reg) begin
                    state_next = got_pkg::S_FINISH;
                end else begin
                    st_rd_en = 1'b1;
                    st_rd_addr = got_pkg::PT_IDX_W'(p_next);
                    state_next = got_pkg::S_LOAD;
                end
            end
            got_pkg::S_FINISH: begin
                if (!res_valid_reg || results.ready) begin
                    res_next = best_reg;
                    res_valid_next = 1'b1;
                    state_next = got_pkg::S_IDLE;
                end
            end
            default: state_next = got_pkg::S_IDLE;
        endcase
    end

    `GOT_ASSERT_NOW(a_div_done_waited, div_done, (state_reg == got_pkg::S_RATIO || state_reg == got_pkg::S_XDIV))
    `GOT_ASSERT_NOW(a_point_in_range, (state_reg != got_pkg::S_IDLE), (p_reg <= n_reg))
    `GOT_ASSERT_NEXT(a_map_starts_ratio, (item_acc && items.operation == got_pkg::OP_MAP), (state_reg == got_pkg::S_RATIO))

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the Gaussian opacity transfer unit.
// Depends on got_pkg, the got_*_if interfaces and the unit's top level.
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 60;

    logic clk;
    logic rst_n;

    got_cfg_if    cfg_if();
    got_item_if   item_if();
    got_result_if res_if();

    gaussian_opacity_transfer_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if.source),
        .items   (item_if.source),
        .results (res_if.sink)
    );

    typedef struct {
        logic        operation;
        logic [15:0] sample;
        logic [3:0]  point_index;
        logic [15:0] center;
        logic [14:0] peak;
        logic [14:0] half_width;
        logic [15:0] skew_x;
        logic [15:0] shape_y;
    } opacity_item_t;

    // Predictor state.
    logic [15:0] mdl_range_low;
    logic [15:0] mdl_range_high;
    logic [4:0]  mdl_point_count;
    logic [15:0] pt_center [got_pkg::MAX_POINTS];
    logic [14:0] pt_peak [got_pkg::MAX_POINTS];
    logic [14:0] pt_half_width [got_pkg::MAX_POINTS];
    logic [15:0] pt_skew_x [got_pkg::MAX_POINTS];
    logic [15:0] pt_shape_y [got_pkg::MAX_POINTS];
    longint unsigned gauss_tab [got_pkg::GAUSS_ROM_ENTRIES];

    logic [14:0] opacity_expected [$];
    int error_count;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint unsigned gauss_sample(longint unsigned i);
        longint unsigned half;
        longint unsigned n1;
        longint unsigned m;
        longint unsigned den;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned a3;
        longint unsigned a4;
        longint unsigned e;
        half = 64'd1 << 29;
        n1 = got_pkg::GAUSS_ROM_ENTRIES - 1;
        m = (2 * i >= n1) ? 2 * i - n1 : n1 - 2 * i;
        den = n1 * n1;
        a = (((m * m) << 24) + den / 2) / den;
        a2 = (a * a + half) >> 30;
        a3 = (a2 * a + half) >> 30;
        a4 = (a3 * a + half) >> 30;
        e = (64'd1 << 30) - a + a2 / 2 - a3 / 6 + a4 / 24;
        for (int k = 0; k < 8; k++)
        begin
            e = (e * e + half) >> 30;
        end
        return (e * 16384 + half) >> 30;
    endfunction

    function automatic longint curve_value(longint ratio, int p);
        longint c;
        longint w0;
        longint k;
        longint y;
        longint pk;
        longint d;
        longint w;
        longint x;
        longint xc;
        longint par;
        longint g;
        longint s;
        longint v;
        longint idx;
        c = longint'($signed(pt_center[p]));
        w0 = longint'(pt_half_width[p]);
        k = longint'($signed(pt_skew_x[p]));
        y = longint'(pt_shape_y[p]);
        pk = longint'(pt_peak[p]);
        if (ratio > c + w0 || ratio < c - w0)
            return 0;
        d = ratio - c;
        w = (w0 == 0) ? 1 : w0;
        if (k == 0 || d == k)
            x = (d * 16384) / w;
        else if (d > k)
            x = (w == k) ? 0 : ((d - k) * 16384) / (w - k);
        else
            x = (w == -k) ? 0 : ((k - d) * 16384) / (w + k);
        if (x > (64'sd1 << 20))
            x = 64'sd1 << 20;
        if (x < -(64'sd1 << 20))
            x = -(64'sd1 << 20);
        par = 16384 - ((x * x) >>> 14);
        xc = (x > 16384) ? 16384 : ((x < -16384) ? -16384 : x);
        idx = ((xc + 16384) * (got_pkg::GAUSS_ROM_ENTRIES - 1) + 16384) >>> 15;
        if (idx > got_pkg::GAUSS_ROM_ENTRIES - 1)
            idx = got_pkg::GAUSS_ROM_ENTRIES - 1;
        g = longint'(gauss_tab[idx]);
        if (y < 16384)
            s = y * par + (16384 - y) * g;
        else
            s = (32768 - y) * par + (y - 16384) * 16384;
        if (s <= 0)
            return 0;
        v = (s * pk + (64'sd1 << 27)) >>> 28;
        return (v > 32767) ? 32767 : v;
    endfunction

    function automatic logic [14:0] peak_opacity(logic [15:0] sample);
        longint lo;
        longint delta;
        longint ratio;
        longint best;
        longint v;
        int n;
        lo = longint'($signed(mdl_range_low));
        delta = longint'($signed(mdl_range_high)) - lo;
        if (delta == 0)
            delta = 1;
        ratio = ((longint'($signed(sample)) - lo) * 16384) / delta;
        n = (mdl_point_count > got_pkg::MAX_POINTS) ? got_pkg::MAX_POINTS
                                                    : int'(mdl_point_count);
        best = 0;
        for (int p = 0; p < n; p++)
        begin
            v = curve_value(ratio, p);
            if (v > best)
                best = v;
        end
        return best[14:0];
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Result side: random stalls and comparison against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (opacity_expected.size() == 0)
                    report_mismatch("opacity beat with nothing pending", res_if.opacity, -1);
                else if (res_if.opacity !== opacity_expected[0])
                    report_mismatch("opacity", res_if.opacity, opacity_expected.pop_front());
                else
                    void'(opacity_expected.pop_front());
            end
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // A beat stays valid after its accepting edge until the next beat or
    // another channel takes over, so nothing is driven twice in one step.
    task automatic send_item(opacity_item_t it);
        cfg_if.valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.operation <= it.operation;
        item_if.sample <= it.sample;
        item_if.point_index <= it.point_index;
        item_if.center <= it.center;
        item_if.peak <= it.peak;
        item_if.half_width <= it.half_width;
        item_if.skew_x <= it.skew_x;
        item_if.shape_y <= it.shape_y;
        do
            @(posedge clk);
        while (!item_if.ready);
        if (it.operation == got_pkg::OP_WRITE)
        begin
            pt_center[it.point_index] = it.center;
            pt_peak[it.point_index] = it.peak;
            pt_half_width[it.point_index] = it.half_width;
            pt_skew_x[it.point_index] = it.skew_x;
            pt_shape_y[it.point_index] = it.shape_y;
        end
        else
        begin
            opacity_expected.push_back(peak_opacity(it.sample));
        end
    endtask

    task automatic write_register(logic [got_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
        item_if.valid <= 1'b0;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            got_pkg::CFG_RANGE_LOW: mdl_range_low = value;
            got_pkg::CFG_RANGE_HIGH: mdl_range_high = value;
            got_pkg::CFG_POINT_COUNT: mdl_point_count = value[4:0];
            default: ;
        endcase
    endtask

    // Waits until every opacity has come back and the unit has gone quiet.
    task automatic drain();
        item_if.valid <= 1'b0;
        wait (opacity_expected.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic map_sample(logic [15:0] sample);
        opacity_item_t it;
        it = '{default: '0};
        it.operation = got_pkg::OP_MAP;
        it.sample = sample;
        it.point_index = 4'($urandom);
        send_item(it);
    endtask

    task automatic write_point(int idx, int c, int pk, int hw, int k, int y);
        opacity_item_t it;
        it.operation = got_pkg::OP_WRITE;
        it.sample = 16'($urandom);
        it.point_index = 4'(idx);
        it.center = 16'(c);
        it.peak = 15'(pk);
        it.half_width = 15'(hw);
        it.skew_x = 16'(k);
        it.shape_y = 16'(y);
        send_item(it);
    endtask

    task automatic test_directed_points();
        map_sample(16'd1234);
        drain();
        write_register(got_pkg::CFG_RANGE_HIGH, 16'd16384);
        write_point(0, 0, 16384, 0, 0, 0);
        write_point(1, 8192, 16384, 16384, 16384, 16384);
        write_point(2, -32768, 32767, 16384, -16384, 32768);
        write_point(3, 32767, 32767, 32767, 32767, 65535);
        write_point(4, 4000, 20000, 3000, -3000, 8000);
        write_register(got_pkg::CFG_POINT_COUNT, 16'd5);
        map_sample(16'd0);
        map_sample(16'd1);
        map_sample(16'd8192);
        map_sample(16'h8000);
        map_sample(16'h7fff);
        map_sample(16'd1000);
        map_sample(16'd7000);
        map_sample(16'hffff);
        drain();
    endtask

    task automatic test_empty_range();
        write_register(got_pkg::CFG_RANGE_LOW, 16'd5);
        write_register(got_pkg::CFG_RANGE_HIGH, 16'd5);
        map_sample(16'd5);
        map_sample(16'd6);
        map_sample(16'h8000);
        drain();
    endtask

    function automatic logic [15:0] near_point_sample();
        longint lo;
        longint delta;
        longint target;
        longint s;
        int p;
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        p = $urandom_range(got_pkg::MAX_POINTS - 1);
        target = longint'($signed(pt_center[p]))
                 + $urandom_range(2 * pt_half_width[p] + 100) - pt_half_width[p] - 50;
        lo = longint'($signed(mdl_range_low));
        delta = longint'($signed(mdl_range_high)) - lo;
        s = lo + (target * delta) / 16384;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return s[15:0];
    endfunction

    task automatic random_point_write(int idx);
        int hw;
        if ($urandom_range(3) == 0)
        begin
            write_point(idx, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            hw = ($urandom_range(7) == 0) ? 0 : $urandom_range(16384);
            write_point(idx, $urandom_range(32768) - 8192, $urandom_range(16384), hw,
                        $urandom_range(2 * hw) - hw, $urandom_range(32768));
        end
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int n_items,
                                     logic [15:0] lo, logic [15:0] hi, logic [15:0] cnt);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_register(got_pkg::CFG_RANGE_LOW, lo);
        write_register(got_pkg::CFG_RANGE_HIGH, hi);
        write_register(got_pkg::CFG_POINT_COUNT, cnt);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(4) == 0)
                random_point_write($urandom_range(got_pkg::MAX_POINTS - 1));
            else
                map_sample(near_point_sample());
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_cycles = 0;
        cfg_if.valid = 1'b0;
        cfg_if.index = got_pkg::CFG_RANGE_LOW;
        cfg_if.data = '0;
        item_if.valid = 1'b0;
        item_if.operation = got_pkg::OP_MAP;
        item_if.sample = '0;
        item_if.point_index = '0;
        item_if.center = '0;
        item_if.peak = '0;
        item_if.half_width = '0;
        item_if.skew_x = '0;
        item_if.shape_y = '0;
        res_if.ready = 1'b0;
        mdl_range_low = 16'd0;
        mdl_range_high = 16'd32767;
        mdl_point_count = 5'd0;
        for (int i = 0; i < got_pkg::GAUSS_ROM_ENTRIES; i++)
        begin
            gauss_tab[i] = gauss_sample(i);
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_points();
        test_empty_range();

        // Fill the whole store so that any point count reads written points only.
        write_register(got_pkg::CFG_POINT_COUNT, 16'd0);
        for (int p = 0; p < got_pkg::MAX_POINTS; p++)
        begin
            random_point_write(p);
        end
        test_random_phase(0, 0, 475, 16'd0, 16'd16384, 16'd16);
        test_random_phase(86, 0, 475, 16'h8000, 16'h7fff, 16'd31);
        test_random_phase(0, 86, 475, 16'($urandom), 16'($urandom),
                          16'($urandom_range(1, got_pkg::MAX_POINTS)));
        test_random_phase(20, 20, 475, 16'h7fff, 16'h8000, 16'hffe3);

        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
